// ===== sv/rracs_pkg.sv =====
`default_nettype none

package rracs_pkg;

    // Field widths fixed by the item formats.
    localparam int DATA_W  = 32;
    localparam int POS_W   = 13;
    localparam int COUNT_W = 13;
    localparam int LEN_W   = 13;

    // Default depth of the element store.
    localparam int MAX_LEN_DEF = 4096;

    // Reset value of the length register.
    localparam logic [LEN_W-1:0] LENGTH_RESET = 13'd4096;

    // Configuration port: paddr width and register index of length.
    localparam int   CFG_ADDR_W = 3;
    localparam logic REG_LENGTH = 1'b0;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_COUNT   = 2'd1,
        KIND_ASSIGN  = 2'd2,
        KIND_REVERSE = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT,
        ST_CNT_LAST,
        ST_RESULT,
        ST_ASG,
        ST_REV_RDI,
        ST_REV_RDJ,
        ST_REV_WRI,
        ST_REV_WRJ
    } state_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic               range_error;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/rracs_mem.sv =====
`default_nettype none

module rracs_mem #(
    parameter int MAX_LEN = rracs_pkg::MAX_LEN_DEF,
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [rracs_pkg::DATA_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [rracs_pkg::DATA_W-1:0]  rd_data
);
    import rracs_pkg::*;

    logic [DATA_W-1:0] mem_arr [MAX_LEN];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_arr[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_arr[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/rracs_ctrl.sv =====
`default_nettype none

module rracs_ctrl #(
    parameter int MAX_LEN = rracs_pkg::MAX_LEN_DEF,
    parameter int AW      = $clog2(MAX_LEN),
    parameter int UW      = ($clog2(MAX_LEN + 1) > 13) ? $clog2(MAX_LEN + 1) : 13
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rracs_pkg::kind_t              in_kind,
    input  wire logic [rracs_pkg::POS_W-1:0]   in_left,
    input  wire logic [rracs_pkg::POS_W-1:0]   in_right,
    input  wire logic [rracs_pkg::DATA_W-1:0]  in_value,
    input  wire logic [UW-1:0]                 used_len,
    input  wire logic                          out_free,
    output rracs_pkg::res_t                    res,
    output logic                               wr_en,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [rracs_pkg::DATA_W-1:0]  wr_data,
    output logic                               rd_en,
    output logic      [AW-1:0]                 rd_addr,
    input  wire logic [rracs_pkg::DATA_W-1:0]  rd_data
);
    import rracs_pkg::*;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   i_reg, i_next;
    logic [POS_W-1:0]   j_reg, j_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  tmp_reg, tmp_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               err_reg, err_next;

    logic               range_ok;
    logic               load_ok;
    logic               hit;
    logic [POS_W-1:0]   left_m1;

    // Range checks on the incoming request.
    assign left_m1  = in_left - POS_W'(1);
    assign range_ok = (in_left != '0) && (in_left <= in_right)
                      && (UW'(in_right) <= used_len);
    assign load_ok  = (in_left != '0) && (UW'(in_left) <= used_len);

    // The signed compare of the read element against the threshold.
    assign hit = ($signed(rd_data) >= $signed(val_reg));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_kind)
                        KIND_LOAD:    state_next = ST_IDLE;
                        KIND_COUNT:   state_next = range_ok ? ST_CNT : ST_RESULT;
                        KIND_ASSIGN:  state_next = range_ok ? ST_ASG : ST_IDLE;
                        KIND_REVERSE: state_next = range_ok ? ST_REV_RDI : ST_IDLE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CNT:      state_next = (i_reg == j_reg) ? ST_CNT_LAST : ST_CNT;
            ST_CNT_LAST: state_next = ST_RESULT;
            ST_RESULT:   state_next = out_free ? ST_IDLE : ST_RESULT;
            ST_ASG:      state_next = (i_reg == j_reg) ? ST_IDLE : ST_ASG;
            ST_REV_RDI:  state_next = (i_reg < j_reg) ? ST_REV_RDJ : ST_IDLE;
            ST_REV_RDJ:  state_next = ST_REV_WRI;
            ST_REV_WRI:  state_next = ST_REV_WRJ;
            ST_REV_WRJ:  state_next = ST_REV_RDI;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        in_ready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = AW'(i_reg);
        wr_data         = val_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(i_reg);
        res.valid       = 1'b0;
        res.count       = cnt_reg;
        res.range_error = err_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                // A load is written in the cycle it is accepted.
                if (in_valid && (in_kind == KIND_LOAD) && load_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(left_m1);
                    wr_data = in_value;
                end
            end
            ST_CNT: begin
                rd_en = 1'b1;
            end
            ST_RESULT: begin
                res.valid = 1'b1;
            end
            ST_ASG: begin
                wr_en = 1'b1;
            end
            ST_REV_RDI: begin
                rd_en = (i_reg < j_reg);
            end
            ST_REV_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = AW'(j_reg);
            end
            ST_REV_WRI: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
            end
            ST_REV_WRJ: begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                wr_data = tmp_reg;
            end
            default: begin
            end
        endcase
    end

    // Datapath registers: walk indexes, threshold, swap buffer, counter, read-pending flag and error flag.
    always_comb begin
        i_next    = i_reg;
        j_next    = j_reg;
        val_next  = val_reg;
        err_next  = err_reg;
        tmp_next  = (state_reg == ST_REV_RDJ) ? rd_data : tmp_reg;
        pend_next = (state_reg == ST_CNT);
        cnt_next  = cnt_reg + COUNT_W'(pend_reg && hit);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    i_next   = left_m1;
                    j_next   = in_right - POS_W'(1);
                    val_next = in_value;
                    cnt_next = '0;
                    err_next = !range_ok;
                end
            end
            ST_CNT, ST_ASG: begin
                i_next = i_reg + POS_W'(1);
            end
            ST_REV_WRJ: begin
                i_next = i_reg + POS_W'(1);
                j_next = j_reg - POS_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        i_reg   <= i_next;
        j_reg   <= j_next;
        val_reg <= val_next;
        tmp_reg <= tmp_next;
        cnt_reg <= cnt_next;
        err_reg <= err_next;
    end

endmodule

`default_nettype wire

// ===== sv/range_reverse_assign_count_store_top.sv =====
`default_nettype none

// Range store of signed 32-bit elements in a single-port-read memory. A load
// with a valid position is written in the cycle that accepts it. A count
// reads the range of N elements, then hands the result to the output
// register, and stalls there while that register still holds an unread
// result; a bad range answers with the error flag and count 0. An assign
// writes the value over the range. A reverse swaps pairs from the ends
// inward until the indexes meet. A bad assign or reverse range returns to
// idle without touching memory. Through the one memory read port the
// sequencer walks the range one element per cycle and swaps each pair in
// the states read i, read j, write i, write j. No request is taken while
// one is at work; a finished result waits in the output register while the
// next request is accepted. No clearing pass: elements read before they
// are written hold unknown values.
module range_reverse_assign_count_store_top #(
    parameter int MAX_LEN = rracs_pkg::MAX_LEN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input requests.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: left [12:0], right [25:13], value [57:26], zero [63:58].
    input  wire logic [63:0]                       s_tdata,
    // s_tuser: kind [1:0].
    input  wire logic [1:0]                        s_tuser,
    // Results.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: count [12:0], zero [15:13].
    output logic      [15:0]                       m_tdata,
    // m_tuser: range_error [0].
    output logic                                   m_tuser,
    // Configuration.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rracs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);
    import rracs_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int UW = ($clog2(MAX_LEN + 1) > 13) ? $clog2(MAX_LEN + 1) : 13;

    logic [LEN_W-1:0]   length_reg;
    logic [UW-1:0]      used_len;
    logic               cfg_wr;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_err_reg;
    logic               out_free;

    res_t               res;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DATA_W-1:0]  rd_data;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LENGTH);
    assign prdata = (paddr[2] == REG_LENGTH) ? 32'(length_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= LENGTH_RESET;
        end else if (cfg_wr) begin
            length_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Length in use, saturated to the store depth.
    assign used_len = (UW'(length_reg) > UW'(MAX_LEN)) ? UW'(MAX_LEN) : UW'(length_reg);

    rracs_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .UW      (UW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (kind_t'(s_tuser)),
        .in_left  (s_tdata[12:0]),
        .in_right (s_tdata[25:13]),
        .in_value (s_tdata[57:26]),
        .used_len (used_len),
        .out_free (out_free),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    rracs_mem #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register; it takes a new result once the old one is gone.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res.valid;
        end
        if (out_free && res.valid) begin
            out_count_reg <= res.count;
            out_err_reg   <= res.range_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 16'(out_count_reg);
    assign m_tuser  = out_err_reg;

    // A pending result means the sequencer is not taking requests.
    a_busy_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !s_tready)
        else $error("request accepted while a result is pending");

    // An error result always carries a zero count.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 16'd0))
        else $error("error result with nonzero count");

    // A load finishes in its own cycle.
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_LOAD)) |=> s_tready)
        else $error("load kept the block busy");

    // Memory is never read and written in the same cycle.
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> 1'b0)
        else $error("memory read and write in the same cycle");

endmodule

`default_nettype wire
